// ===== rtl/vector_normalize_truncate_macros.svh =====
// Assertion macros for the vector normalize / truncate block.
// Used by the port checker; no other dependencies.
`ifndef VECTOR_NORMALIZE_TRUNCATE_MACROS_SVH
`define VECTOR_NORMALIZE_TRUNCATE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define VNT_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("vnt: implication failed");

// Antecedent implies consequent in the next cycle.
`define VNT_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("vnt: next-cycle check failed");

`endif

// ===== rtl/vnt_pkg.sv =====
// Shared types, constants and helpers for the vector normalize / truncate block.
// No dependencies.
package vnt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DW          = 32;
  localparam int ML_W        = 31;
  localparam int QW          = FRAC_BITS + 1;
  localparam int SQRT_STAGES = DW;
  localparam int LANES       = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic [DW-1:0]   ONE       = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [ML_W-1:0] ML_RESET  = {{(ML_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  typedef enum logic [1:0] {
    CMD_NORM3 = 2'd0,
    CMD_NORM2 = 2'd1,
    CMD_TRUNC = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]           cmd;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t            vec;
    logic [2*DW-1:0] sq;
  } front_item_t;

  typedef struct packed {
    vec_t vec;
    logic zero;
    logic trunc;
  } back_ctl_t;

  function automatic logic [DW-1:0] magnitude(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic [DW-1:0] with_sign(input logic neg, input logic [DW-1:0] m);
    return neg ? DW'(-m) : m;
  endfunction

endpackage

// ===== rtl/vector_normalize_truncate.sv =====
// Top level of the vector normalize / truncate block: front end, queue,
// square root and divider pipelines, scaling and output register.
// Depends on vnt_pkg, vnt_front, vnt_fifo, vnt_sqrt, vnt_div.
//
//  channel   dir  handshake             payload
//  s_*       in   s_tvalid / s_tready   tuser: cmd; tdata: x_in, y_in, z_in
//  m_*       out  m_tvalid / m_tready   tuser: zero_length, was_truncated;
//                                       tdata: x_out, y_out, z_out
//  cfg_*     in   cfg_we                cfg_wdata: max_length
//
// One vector per cycle unless the output stalls. After the accepting edge a
// result passes a second front stage, the queue write, 32 square-root stages
// (one bit each), 17 divider stages, a multiply stage and the output register.
// Reset clears all valid bits and queue pointers and sets max_length to 1.0.
// The back pipeline stalls as a whole while a result waits at the output;
// the four-entry queue lets the front keep taking beats meanwhile.
module vector_normalize_truncate (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  input  logic [95:0] s_tdata,   // [31:0] x_in, [63:32] y_in, [95:64] z_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [1:0]  m_tuser,   // [0] zero_length, [1] was_truncated
  output logic [95:0] m_tdata,   // [31:0] x_out, [63:32] y_out, [95:64] z_out
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata
);
  import vnt_pkg::*;

  logic                         push;
  front_item_t                  push_item;
  logic                         push_ready;
  logic                         en;
  logic                         pop_valid;
  front_item_t                  pop_item;
  logic                         sq_valid;
  logic [DW-1:0]                sq_root;
  vec_t                         sq_vec;
  back_ctl_t                    div_ctl_in;
  logic [LANES-1:0][DW-1:0]     div_num;
  logic                         div_valid;
  logic [LANES-1:0][QW-1:0]     div_q;
  back_ctl_t                    div_ctl;
  logic [ML_W-1:0]              max_length;
  logic                         vm;
  back_ctl_t                    ctl_m;
  logic [LANES-1:0][QW-1:0]     q_m;
  logic [QW+ML_W-1:0]           px_m;
  logic [QW+ML_W-1:0]           pz_m;
  logic [DW-1:0]                nx;
  logic [DW-1:0]                ny;
  logic [DW-1:0]                nz;
  logic [DW-1:0]                tx;
  logic [DW-1:0]                tz;
  logic [DW-1:0]                rx;
  logic [DW-1:0]                ry;
  logic [DW-1:0]                rz;
  logic                         r_zero;
  logic                         r_trunc;

  assign en = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= ML_RESET;
    end else if (cfg_we) begin
      max_length <= cfg_wdata;
    end
  end

  vnt_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
    .push, .push_item, .push_ready
  );

  vnt_fifo u_fifo (
    .clk, .rst, .push, .push_item, .push_ready,
    .pop (en), .pop_valid, .pop_item
  );

  vnt_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid  (en && pop_valid),
    .in_op     (pop_item.sq),
    .in_vec    (pop_item.vec),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_vec   (sq_vec)
  );

  always_comb begin
    div_ctl_in.vec   = sq_vec;
    div_ctl_in.zero  = sq_root == '0;
    div_ctl_in.trunc = (sq_vec.cmd == CMD_TRUNC) && (sq_root > {1'b0, max_length});
    div_num[0]       = magnitude(sq_vec.x);
    div_num[1]       = magnitude(sq_vec.y);
    div_num[2]       = magnitude(sq_vec.z);
  end

  vnt_div u_div (
    .clk, .rst, .en,
    .in_valid  (sq_valid),
    .in_den    (sq_root),
    .in_num    (div_num),
    .in_ctl    (div_ctl_in),
    .out_valid (div_valid),
    .out_q     (div_q),
    .out_ctl   (div_ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_m <= div_ctl;
      q_m   <= div_q;
      px_m  <= (QW+ML_W)'(div_q[0]) * (QW+ML_W)'(max_length);
      pz_m  <= (QW+ML_W)'(div_q[2]) * (QW+ML_W)'(max_length);
    end
  end

  always_comb begin
    nx = with_sign(ctl_m.vec.x[DW-1], DW'(q_m[0]));
    ny = with_sign(ctl_m.vec.y[DW-1], DW'(q_m[1]));
    nz = with_sign(ctl_m.vec.z[DW-1], DW'(q_m[2]));
    tx = with_sign(ctl_m.vec.x[DW-1], DW'(px_m >> FRAC_BITS));
    tz = with_sign(ctl_m.vec.z[DW-1], DW'(pz_m >> FRAC_BITS));
    rx      = ctl_m.vec.x;
    ry      = ctl_m.vec.y;
    rz      = ctl_m.vec.z;
    r_zero  = 1'b0;
    r_trunc = 1'b0;
    case (ctl_m.vec.cmd)
      CMD_NORM3: begin
        r_zero = ctl_m.zero;
        rx     = ctl_m.zero ? ONE : nx;
        ry     = ctl_m.zero ? ONE : ny;
        rz     = ctl_m.zero ? ONE : nz;
      end
      CMD_NORM2: begin
        r_zero = ctl_m.zero;
        rx     = ctl_m.zero ? ONE : nx;
        ry     = '0;
        rz     = ctl_m.zero ? ONE : nz;
      end
      CMD_TRUNC: begin
        if (ctl_m.trunc) begin
          r_trunc = 1'b1;
          rx      = tx;
          ry      = '0;
          rz      = tz;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {rz, ry, rx};
      m_tuser <= {r_trunc, r_zero};
    end
  end

endmodule

// ===== rtl/vnt_front.sv =====
// Front end: input register, component squares, sum of squares for the command.
// Depends on vnt_pkg.
module vnt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [1:0]         s_tuser,
  input  logic [95:0]        s_tdata,
  output logic               push,
  output vnt_pkg::front_item_t push_item,
  input  logic               push_ready
);
  import vnt_pkg::*;

  logic            en;
  logic            v1;
  logic            v2;
  vec_t            vec1;
  vec_t            vec2;
  logic [DW-1:0]   mx;
  logic [DW-1:0]   my;
  logic [DW-1:0]   mz;
  logic [2*DW-1:0] px;
  logic [2*DW-1:0] py;
  logic [2*DW-1:0] pz;

  assign en       = !v2 || push_ready;
  assign s_tready = en;
  assign push     = v2 && push_ready;

  assign mx = magnitude(vec1.x);
  assign my = magnitude(vec1.y);
  assign mz = magnitude(vec1.z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec1.cmd <= s_tuser;
      vec1.x   <= s_tdata[31:0];
      vec1.y   <= s_tdata[63:32];
      vec1.z   <= s_tdata[95:64];
      vec2     <= vec1;
      px       <= (2*DW)'(mx) * (2*DW)'(mx);
      py       <= (2*DW)'(my) * (2*DW)'(my);
      pz       <= (2*DW)'(mz) * (2*DW)'(mz);
    end
  end

  always_comb begin
    push_item.vec = vec2;
    push_item.sq  = (vec2.cmd == CMD_NORM3) ? px + py + pz : px + pz;
  end

endmodule

// ===== rtl/vnt_fifo.sv =====
// Short queue between the front end and the back end.
// Depends on vnt_pkg.
module vnt_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  vnt_pkg::front_item_t push_item,
  output logic                 push_ready,
  input  logic                 pop,
  output logic                 pop_valid,
  output vnt_pkg::front_item_t pop_item
);
  import vnt_pkg::*;

  front_item_t        mem [FIFO_DEPTH];
  logic [FIFO_AW:0]   wr_ptr;
  logic [FIFO_AW:0]   rd_ptr;
  logic [FIFO_AW:0]   fill;

  assign fill       = wr_ptr - rd_ptr;
  assign push_ready = fill != (FIFO_AW+1)'(FIFO_DEPTH);
  assign pop_valid  = wr_ptr != rd_ptr;
  assign pop_item   = mem[rd_ptr[FIFO_AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && pop_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr[FIFO_AW-1:0]] <= push_item;
    end
  end

endmodule

// ===== rtl/vnt_sqrt.sv =====
// Pipelined floor square root, one root bit per stage, payload carried alongside.
// Depends on vnt_pkg.
module vnt_sqrt (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*vnt_pkg::DW-1:0] in_op,
  input  vnt_pkg::vec_t         in_vec,
  output logic                  out_valid,
  output logic [vnt_pkg::DW-1:0] out_root,
  output vnt_pkg::vec_t         out_vec
);
  import vnt_pkg::*;

  logic            val  [1:SQRT_STAGES];
  logic [2*DW-1:0] op   [1:SQRT_STAGES];
  logic [DW+1:0]   rem  [1:SQRT_STAGES];
  logic [DW-1:0]   root [1:SQRT_STAGES];
  vec_t            vec  [1:SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    logic            c_val;
    logic [2*DW-1:0] c_op;
    logic [DW+1:0]   c_rem;
    logic [DW-1:0]   c_root;
    vec_t            c_vec;
    logic [DW+1:0]   rs;
    logic [DW+1:0]   tr;
    logic            ge;

    if (k == 0) begin : g_first
      assign c_val  = in_valid;
      assign c_op   = in_op;
      assign c_rem  = '0;
      assign c_root = '0;
      assign c_vec  = in_vec;
    end else begin : g_next
      assign c_val  = val[k];
      assign c_op   = op[k];
      assign c_rem  = rem[k];
      assign c_root = root[k];
      assign c_vec  = vec[k];
    end

    assign rs = {c_rem[DW-1:0], c_op[2*DW-1 -: 2]};
    assign tr = {c_root, 2'b01};
    assign ge = rs >= tr;

    always_ff @(posedge clk) begin
      if (rst) begin
        val[k+1] <= 1'b0;
      end else if (en) begin
        val[k+1] <= c_val;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        op[k+1]   <= c_op << 2;
        rem[k+1]  <= ge ? rs - tr : rs;
        root[k+1] <= {c_root[DW-2:0], ge};
        vec[k+1]  <= c_vec;
      end
    end
  end

  assign out_valid = val[SQRT_STAGES];
  assign out_root  = root[SQRT_STAGES];
  assign out_vec   = vec[SQRT_STAGES];

endmodule

// ===== rtl/vnt_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage. Depends on vnt_pkg.
module vnt_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [vnt_pkg::DW-1:0]             in_den,
  input  logic [vnt_pkg::LANES-1:0][vnt_pkg::DW-1:0] in_num,
  input  vnt_pkg::back_ctl_t                 in_ctl,
  output logic                               out_valid,
  output logic [vnt_pkg::LANES-1:0][vnt_pkg::QW-1:0] out_q,
  output vnt_pkg::back_ctl_t                 out_ctl
);
  import vnt_pkg::*;

  logic                         val [1:QW];
  logic [DW-1:0]                den [1:QW];
  logic [LANES-1:0][DW:0]       rem [1:QW];
  logic [LANES-1:0][QW-1:0]     q   [1:QW];
  back_ctl_t                    ctl [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                     c_val;
    logic [DW-1:0]            c_den;
    logic [LANES-1:0][DW:0]   c_rem;
    logic [LANES-1:0][QW-1:0] c_q;
    back_ctl_t                c_ctl;
    logic [LANES-1:0][DW:0]   n_rem;
    logic [LANES-1:0][QW-1:0] n_q;

    if (k == 0) begin : g_first
      assign c_val = in_valid;
      assign c_den = in_den;
      assign c_q   = '0;
      assign c_ctl = in_ctl;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign c_rem[l] = {1'b0, in_num[l]};
      end
    end else begin : g_next
      assign c_val = val[k];
      assign c_den = den[k];
      assign c_rem = rem[k];
      assign c_q   = q[k];
      assign c_ctl = ctl[k];
    end

    always_comb begin
      logic          ge;
      logic [DW:0]   sub;
      for (int l = 0; l < LANES; l++) begin
        ge       = c_rem[l] >= {1'b0, c_den};
        sub      = ge ? c_rem[l] - {1'b0, c_den} : c_rem[l];
        n_rem[l] = {sub[DW-1:0], 1'b0};
        n_q[l]   = {c_q[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        val[k+1] <= 1'b0;
      end else if (en) begin
        val[k+1] <= c_val;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[k+1] <= c_den;
        rem[k+1] <= n_rem;
        q[k+1]   <= n_q;
        ctl[k+1] <= c_ctl;
      end
    end
  end

  assign out_valid = val[QW];
  assign out_q     = q[QW];
  assign out_ctl   = ctl[QW];

endmodule

// ===== rtl/vnt_checker.sv =====
// Port-level checker for the vector normalize / truncate block, bound to the top.
// Depends on vnt_pkg and vector_normalize_truncate_macros.svh.
`include "vector_normalize_truncate_macros.svh"

module vnt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic [95:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [1:0]  m_tuser,
  input logic [95:0] m_tdata,
  input logic        cfg_we,
  input logic [30:0] cfg_wdata
);
  import vnt_pkg::*;

  `VNT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `VNT_ASSERT_IMPLY(a_flags_excl, clk, rst, m_tvalid, !(m_tuser[0] && m_tuser[1]))
  `VNT_ASSERT_IMPLY(a_trunc_y0, clk, rst, m_tvalid && m_tuser[1], m_tdata[63:32] == '0)
  `VNT_ASSERT_IMPLY(a_zero_one, clk, rst, m_tvalid && m_tuser[0], m_tdata[31:0] == ONE && m_tdata[95:64] == ONE)

endmodule

bind vector_normalize_truncate vnt_checker u_vnt_checker (.*);

// ===== verif/tb_vector_normalize_truncate.sv =====
// Testbench for vector_normalize_truncate: random and directed vectors with a
// scoreboard fed by a fixed-point normalize / truncate predictor.
// Depends on vnt_pkg and the vector_normalize_truncate RTL.
module tb_vector_normalize_truncate;
  timeunit 1ns;
  timeprecision 1ps;
  import vnt_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] x, y, z;
  } vec_beat_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic        zero, trunc;
  } norm_res_t;

  typedef struct {
    bit          is_cfg;
    bit          drain;
    logic [30:0] ml;
    vec_beat_t   v;
  } plan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [1:0] s_tuser = '0;
  logic [95:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [1:0] m_tuser;
  logic [95:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;

  vector_normalize_truncate i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  plan_t     pending_q[$];
  norm_res_t expected_q[$];
  logic [30:0] ml_model = 31'd65536;
  int send_idle = 9, recv_idle = 68;
  int hold_cycles = 0;
  int errors = 0;
  int stall_cnt = 0;
  bit stim_done = 1'b0;
  bit holding = 1'b0;
  int wait_cnt = 0;

  function automatic logic [63:0] root_floor(input logic [65:0] n);
    logic [65:0] r, b, t;
    r = 0;
    b = 66'd1 << 64;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      t = r + b;
      if (n >= t) begin
        n = n - t;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[63:0];
  endfunction

  function automatic logic [31:0] sat_sign(input bit neg, input logic [95:0] m);
    if (neg) return (m > 96'h8000_0000) ? 32'h8000_0000 : 32'(-m);
    return (m > 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic logic [31:0] unit_div(input logic [31:0] c, input logic [63:0] len);
    logic [95:0] q;
    q = ({64'd0, mag32(c)} << FRAC_BITS) / {32'd0, len};
    return sat_sign(c[31], q);
  endfunction

  function automatic logic [31:0] scale_by(input logic [31:0] q, input logic [30:0] s);
    logic [95:0] p;
    p = ({64'd0, mag32(q)} * {65'd0, s}) >> FRAC_BITS;
    return sat_sign(q[31], p);
  endfunction

  function automatic norm_res_t predict_norm(input vec_beat_t v, input logic [30:0] ml);
    norm_res_t r;
    logic [65:0] mx, my, mz, psq;
    logic [63:0] len;
    r.x = v.x; r.y = v.y; r.z = v.z; r.zero = 0; r.trunc = 0;
    mx = mag32(v.x); my = mag32(v.y); mz = mag32(v.z);
    psq = mx * mx + mz * mz;
    if (v.cmd == CMD_NORM3) begin
      len = root_floor(psq + my * my);
      if (len == 0) begin
        r.x = ONE; r.y = ONE; r.z = ONE; r.zero = 1;
      end else begin
        r.x = unit_div(v.x, len); r.y = unit_div(v.y, len); r.z = unit_div(v.z, len);
      end
    end else if (v.cmd == CMD_NORM2 || v.cmd == CMD_TRUNC) begin
      len = root_floor(psq);
      if (v.cmd == CMD_NORM2 || len > {33'd0, ml}) begin
        r.y = 0;
        if (len == 0) begin
          r.x = ONE; r.z = ONE; r.zero = 1;
        end else begin
          r.x = unit_div(v.x, len); r.z = unit_div(v.z, len);
        end
        if (v.cmd == CMD_TRUNC) begin
          r.x = scale_by(r.x, ml); r.z = scale_by(r.z, ml); r.trunc = 1;
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_comp(input int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      3: return 32'($signed($urandom_range(0, 600000)) - 300000);
      default: return 32'h0;
    endcase
  endfunction

  task automatic add_vec(input logic [1:0] c, input logic [31:0] x, y, z);
    plan_t p;
    p.is_cfg = 0; p.drain = 0; p.ml = '0;
    p.v.cmd = c; p.v.x = x; p.v.y = y; p.v.z = z;
    pending_q.push_back(p);
  endtask

  task automatic add_cfg(input logic [30:0] ml);
    plan_t p;
    p.is_cfg = 1; p.drain = 1; p.ml = ml; p.v = '{default: '0};
    pending_q.push_back(p);
  endtask

  task automatic add_drain();
    plan_t p;
    p.is_cfg = 0; p.drain = 1; p.ml = '0; p.v = '{default: '0};
    pending_q.push_back(p);
  endtask

  task automatic add_random(input int n);
    logic [1:0] c;
    for (int i = 0; i < n; i++) begin
      c = 2'($urandom_range(0, 19) == 0 ? 3 : $urandom_range(0, 2));
      add_vec(c, rand_comp($urandom_range(0, 4)), rand_comp($urandom_range(0, 4)),
              rand_comp($urandom_range(0, 4)));
    end
  endtask

  initial begin
    add_vec(CMD_NORM3, 0, 0, 0);
    add_vec(CMD_NORM2, 0, 32'h1234, 0);
    add_vec(CMD_TRUNC, 0, 32'hFFFF_0000, 0);
    add_vec(2'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_AAAA);
    add_vec(CMD_NORM3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_vec(CMD_NORM3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_vec(CMD_NORM3, 1, 0, 0);
    add_vec(CMD_NORM3, 32'hFFFF_FFFF, 1, 0);
    add_vec(CMD_NORM2, 32'h8000_0000, 5, 0);
    add_vec(CMD_NORM2, 32'h7FFF_FFFF, 5, 32'h8000_0000);
    add_vec(CMD_NORM2, 0, 9, 32'hFFFF_FFFF);
    add_vec(CMD_TRUNC, 32'h0001_0000, 3, 0);
    add_vec(CMD_TRUNC, 32'h0002_0000, 3, 32'hFFFE_0000);
    add_vec(CMD_TRUNC, 32'h8000_0000, 3, 32'h8000_0000);
    add_vec(CMD_TRUNC, 32'h0000_8000, 3, 32'h0000_8000);
    add_cfg(31'h7FFF_FFFF);
    add_vec(CMD_TRUNC, 32'h8000_0000, 1, 32'h8000_0000);
    add_vec(CMD_TRUNC, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF);
    add_cfg(31'd0);
    add_vec(CMD_TRUNC, 0, 7, 0);
    add_vec(CMD_TRUNC, 1, 7, 0);
    add_vec(CMD_TRUNC, 32'hFFF0_0000, 7, 32'h0010_0000);
    add_random(200);
    add_cfg(31'h0003_0000);
    add_random(200);
    add_drain();
    add_random(100);
    add_cfg(31'($urandom));
    add_random(150);
    add_cfg(31'd65536);
    add_random(180);
  end

  // sender: configuration writes happen only when the pipe is empty and quiet
  always @(posedge clk) begin
    bit we_next;
    we_next = 1'b0;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (!s_tvalid || s_tready) begin
        if (pending_q.size() == 0) begin
          s_tvalid <= 1'b0;
          stim_done <= 1'b1;
        end else if (pending_q[0].drain) begin
          s_tvalid <= 1'b0;
          if (expected_q.size() != 0) wait_cnt <= 0;
          else if (wait_cnt < 70) wait_cnt <= wait_cnt + 1;
          else begin
            wait_cnt <= 0;
            if (pending_q[0].is_cfg) begin
              we_next = 1'b1;
              cfg_wdata <= pending_q[0].ml;
              ml_model <= pending_q[0].ml;
            end
            void'(pending_q.pop_front());
          end
        end else if ($urandom_range(0, 99) < send_idle) begin
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tuser <= pending_q[0].v.cmd;
          s_tdata <= {pending_q[0].v.z, pending_q[0].v.y, pending_q[0].v.x};
          expected_q.push_back(predict_norm(pending_q[0].v, ml_model));
          void'(pending_q.pop_front());
        end
      end
    end
    cfg_we <= we_next;
  end

  // receiver, with one long hold-off while items keep arriving
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!holding && hold_cycles == 0 && pending_q.size() == 700) begin
        holding <= 1'b1;
        hold_cycles <= 1;
        m_tready <= 1'b0;
      end else if (holding) begin
        hold_cycles <= hold_cycles + 1;
        if (hold_cycles >= 300) holding <= 1'b0;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
      if (pending_q.size() == 570) begin
        send_idle <= 68; recv_idle <= 9;
      end else if (pending_q.size() == 280) begin
        send_idle <= 0; recv_idle <= 0;
      end
    end
  end

  // scoreboard
  always @(posedge clk) begin
    norm_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected beat: %h %h", m_tuser, m_tdata);
      end else begin
        e = expected_q.pop_front();
        if (m_tdata[31:0] !== e.x || m_tdata[63:32] !== e.y || m_tdata[95:64] !== e.z ||
            m_tuser[0] !== e.zero || m_tuser[1] !== e.trunc) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: exp x=%h y=%h z=%h zl=%b tr=%b got x=%h y=%h z=%h zl=%b tr=%b",
                     e.x, e.y, e.z, e.zero, e.trunc, m_tdata[31:0], m_tdata[63:32],
                     m_tdata[95:64], m_tuser[0], m_tuser[1]);
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > 5000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && expected_q.size() == 0);
    repeat (80) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/vnt_pkg.sv
rtl/vnt_front.sv
rtl/vnt_fifo.sv
rtl/vnt_sqrt.sv
rtl/vnt_div.sv
rtl/vector_normalize_truncate.sv
rtl/vnt_checker.sv
verif/tb_vector_normalize_truncate.sv
